@@ hdl/efr_pkg.sv @@
// Shared constants, types and pixel math for the edge-flag rasterizer.
`timescale 1ns / 1ps
package efr_pkg;

    localparam int SAMPLES         = 8;
    localparam int SAMPLE_W        = 3;
    localparam int DEF_TILE_WIDTH  = 64;
    localparam int DEF_TILE_HEIGHT = 64;
    localparam int X_W             = 34;
    localparam int OUT_Q_DEPTH     = 4;

    localparam logic [31:0] RB_MASK = 32'h00ff00ff;
    localparam logic [31:0] XG_MASK = 32'hff00ff00;

    typedef enum logic
    {
        FUNC_EDGE = 1'b0,
        FUNC_FILL = 1'b1
    } func_t;

    typedef enum logic
    {
        REG_FILL_COLOR     = 1'b0,
        REG_SAMPLE_OFFSETS = 1'b1
    } reg_index_t;

    typedef logic [3:0] cov_t;

    function automatic cov_t popcount8(input logic [7:0] m);
        cov_t n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + cov_t'(m[i]);
        end
        return n;
    endfunction

    // Blend two channel pairs at once; lanes are 16 bits apart so they never carry into each other.
    function automatic logic [31:0] blend(input logic [31:0] d, input logic [31:0] c,
                                          input cov_t a);
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] p1;
        logic [31:0] p2;
        wa = 32'(a);
        wb = 32'(SAMPLES) - wa;
        p1 = (((d & RB_MASK) * wb + (c & RB_MASK) * wa) >> SAMPLE_W) & RB_MASK;
        p2 = ((((d >> 8) & RB_MASK) * wb + ((c >> 8) & RB_MASK) * wa) << (8 - SAMPLE_W))
             & XG_MASK;
        if (a == '0)
        begin
            return d;
        end
        else if (a >= cov_t'(SAMPLES))
        begin
            return c;
        end
        return p1 + p2;
    endfunction

endpackage

@@ hdl/efr_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-old on collision).
`timescale 1ns / 1ps
module efr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/edge_flag_evenodd_rasterizer.sv @@
// Even-odd 8-sample edge-flag rasterizer: flag-cell store, edge walker and pixel blend.
//
// The tile's flag cells live in one RAM of TILE_HEIGHT * 2**ceil(log2(TILE_WIDTH)) bytes,
// worked as a read-modify-write pipeline through its single read and write port, with a
// one-entry write-back forward for back-to-back hits on the same cell. After reset the
// block sweeps that RAM to zero, one cell per cycle, and takes no word until the sweep
// ends; configuration writes are taken at any time. Fills stream one per cycle while
// fewer than four results are pending; each result passes the read-modify-write and
// blend registers into a four-word output queue. An add-edge word is walked one subline
// at a time (last_subline - first_subline + 1 sublines), one RAM access each, and no
// word is taken until the walk ends; a reversed edge is taken and does nothing.
`timescale 1ns / 1ps
module edge_flag_evenodd_rasterizer #(
    parameter int TILE_WIDTH  = efr_pkg::DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT = efr_pkg::DEF_TILE_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  efr_pkg::reg_index_t cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [21:0]         x_start,
    input  logic signed [22:0]  slope,
    input  logic [8:0]          first_subline,
    input  logic [8:0]          last_subline,
    input  logic [5:0]          row,
    input  logic [5:0]          column,
    input  logic [31:0]         dest_pixel,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_pixel,
    output efr_pkg::cov_t       coverage
);

    import efr_pkg::*;

    localparam int COL_W  = $clog2(TILE_WIDTH);
    localparam int DEPTH  = TILE_HEIGHT * (2 ** COL_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(OUT_Q_DEPTH + 1);
    localparam int QPTR_W = $clog2(OUT_Q_DEPTH);

    localparam logic [17:0]       COL_LIMIT = 18'(TILE_WIDTH);
    localparam logic [12:0]       ROW_LIMIT = 13'(TILE_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } state_t;

    // configuration
    logic [31:0] fill_color_reg;
    logic [63:0] sample_offsets_reg;

    // control and edge walker
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic signed [X_W-1:0]   x_reg, x_next;
    logic signed [22:0]      slope_reg, slope_next;
    logic [8:0]              line_reg, line_next;
    logic [8:0]              last_reg, last_next;
    logic [QCNT_W-1:0]       pending_reg, pending_next;

    // read-modify-write stage
    logic                    b_valid_reg, b_valid_next;
    logic                    b_fill_reg, b_fill_next;
    logic                    b_hit_reg, b_hit_next;
    logic                    b_col0_reg, b_col0_next;
    logic [ADDR_W-1:0]       b_addr_reg, b_addr_next;
    logic [7:0]              b_bit_reg, b_bit_next;
    logic [31:0]             b_dest_reg, b_dest_next;
    logic                    wb_valid_reg;
    logic [ADDR_W-1:0]       wb_addr_reg;
    logic [7:0]              wb_data_reg;
    logic [7:0]              mask_reg, mask_next;

    // blend stage
    logic                    c_valid_reg;
    cov_t                    c_cov_reg;
    logic [31:0]             c_dest_reg;

    // output queue
    logic [31:0]             q_pixel [OUT_Q_DEPTH];
    cov_t                    q_cov [OUT_Q_DEPTH];
    logic [QPTR_W-1:0]       q_wr_reg, q_rd_reg;
    logic [QCNT_W-1:0]       q_cnt_reg;

    logic                    accept, is_fill, pop, walking, clearing;
    logic [2:0]              w_s;
    logic [5:0]              w_r;
    logic [7:0]              w_off;
    logic signed [X_W-1:0]   w_xp;
    logic [17:0]             w_col;
    logic                    w_hit;
    logic [ADDR_W-1:0]       w_addr;
    logic                    f_hit;
    logic [ADDR_W-1:0]       f_addr;
    logic [ADDR_W-1:0]       ram_raddr, ram_waddr;
    logic [7:0]              ram_rdata, ram_wdata;
    logic                    ram_we;
    logic [7:0]              b_cell, b_wdata;
    logic                    b_we;
    logic [31:0]             c_pixel;

    assign clearing = (state_reg == ST_CLEAR);
    assign walking  = (state_reg == ST_WALK);
    assign is_fill  = (func_t'(func) == FUNC_FILL);
    assign in_ready = (state_reg == ST_IDLE) && (pending_reg < QCNT_W'(OUT_Q_DEPTH));
    assign accept   = in_valid && in_ready;
    assign out_valid = (q_cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_pixel = q_pixel[q_rd_reg];
    assign coverage  = q_cov[q_rd_reg];

    // edge walker: place this subline's toggle
    assign w_s    = line_reg[2:0];
    assign w_r    = line_reg[8:3];
    assign w_off  = sample_offsets_reg[{w_s, 3'b000} +: 8];
    assign w_xp   = x_reg + $signed({{(X_W - 16){1'b0}}, w_off, 8'h00});
    assign w_col  = w_xp[X_W-1:16];
    assign w_hit  = !w_xp[X_W-1] && ({7'd0, w_r} < ROW_LIMIT) && (w_col < COL_LIMIT);
    assign w_addr = (ADDR_W'(w_r) << COL_W) | ADDR_W'(w_col[COL_W-1:0]);

    assign f_hit  = ({7'd0, row} < ROW_LIMIT) && ({12'd0, column} < COL_LIMIT);
    assign f_addr = (ADDR_W'(row) << COL_W) | ADDR_W'(column);

    assign ram_raddr = walking ? w_addr : f_addr;

    // forward last cycle's write; the RAM returns the old cell on a same-cycle hit
    assign b_cell  = (wb_valid_reg && (wb_addr_reg == b_addr_reg)) ? wb_data_reg : ram_rdata;
    assign b_we    = b_valid_reg && b_hit_reg;
    assign b_wdata = b_fill_reg ? 8'h00 : (b_cell ^ b_bit_reg);

    assign ram_we    = clearing || b_we;
    assign ram_waddr = clearing ? clr_addr_reg : b_addr_reg;
    assign ram_wdata = clearing ? 8'h00 : b_wdata;

    assign c_pixel = blend(c_dest_reg, fill_color_reg, c_cov_reg);

    efr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_flag_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        x_next        = x_reg;
        slope_next    = slope_reg;
        line_next     = line_reg;
        last_next     = last_reg;
        pending_next  = pending_reg + QCNT_W'(accept && is_fill) - QCNT_W'(pop);

        b_valid_next = 1'b0;
        b_fill_next  = b_fill_reg;
        b_hit_next   = b_hit_reg;
        b_col0_next  = b_col0_reg;
        b_addr_next  = b_addr_reg;
        b_bit_next   = b_bit_reg;
        b_dest_next  = b_dest_reg;

        mask_next = mask_reg;
        if (b_valid_reg && b_fill_reg)
        begin
            mask_next = (b_col0_reg ? 8'h00 : mask_reg) ^ (b_hit_reg ? b_cell : 8'h00);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_fill)
                    begin
                        b_valid_next = 1'b1;
                        b_fill_next  = 1'b1;
                        b_hit_next   = f_hit;
                        b_col0_next  = (column == '0);
                        b_addr_next  = f_addr;
                        b_dest_next  = dest_pixel;
                    end
                    else if (last_subline >= first_subline)
                    begin
                        x_next     = X_W'($signed({1'b0, x_start}));
                        slope_next = slope;
                        line_next  = first_subline;
                        last_next  = last_subline;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // drop toggles that fall outside the tile; x advances regardless
                b_valid_next = w_hit;
                b_fill_next  = 1'b0;
                b_hit_next   = 1'b1;
                b_addr_next  = w_addr;
                b_bit_next   = 8'h01 << w_s;
                x_next       = x_reg + X_W'(slope_reg);
                line_next    = line_reg + 1'b1;
                if (line_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pending_reg  <= '0;
            b_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
            mask_reg     <= 8'h00;
            c_valid_reg  <= 1'b0;
            q_wr_reg     <= '0;
            q_rd_reg     <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pending_reg  <= pending_next;
            b_valid_reg  <= b_valid_next;
            wb_valid_reg <= b_we;
            mask_reg     <= mask_next;
            c_valid_reg  <= b_valid_reg && b_fill_reg;
            if (c_valid_reg)
            begin
                q_wr_reg <= q_wr_reg + 1'b1;
            end
            if (pop)
            begin
                q_rd_reg <= q_rd_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + QCNT_W'(c_valid_reg) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        slope_reg   <= slope_next;
        line_reg    <= line_next;
        last_reg    <= last_next;
        b_fill_reg  <= b_fill_next;
        b_hit_reg   <= b_hit_next;
        b_col0_reg  <= b_col0_next;
        b_addr_reg  <= b_addr_next;
        b_bit_reg   <= b_bit_next;
        b_dest_reg  <= b_dest_next;
        wb_addr_reg <= b_addr_reg;
        wb_data_reg <= b_wdata;
        c_cov_reg   <= popcount8(mask_next);
        c_dest_reg  <= b_dest_reg;
        if (c_valid_reg)
        begin
            q_pixel[q_wr_reg] <= c_pixel;
            q_cov[q_wr_reg]   <= c_cov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg     <= '0;
            sample_offsets_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FILL_COLOR:     fill_color_reg     <= cfg_data[31:0];
                REG_SAMPLE_OFFSETS: sample_offsets_reg <= cfg_data;
                default:            fill_color_reg     <= fill_color_reg;
            endcase
        end
    end

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (q_cnt_reg != QCNT_W'(OUT_Q_DEPTH) || pop))
        else $error("output queue overflow");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("word accepted while clearing or walking");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!b_valid_reg && !c_valid_reg && !wb_valid_reg))
        else $error("cell access during clearing sweep");

    a_pending_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg >= q_cnt_reg)
        else $error("pending count below queue fill");

endmodule
